FILE: rtl/lrc_pkg.sv
`default_nettype none

package lrc_pkg;

	localparam int DEPTH_DEF = 8;
	localparam int KEY_W     = 64;
	localparam int VAL_W     = 32;
	localparam int CNT_W     = 4;
	localparam int SUM_W     = 35;
	localparam int TOT_W     = 36;
	localparam int CTR_W     = 32;

	localparam logic [CNT_W-1:0] CAP_RESET = 4'd8;

endpackage

`default_nettype wire

FILE: rtl/lrc_match.sv
`default_nettype none

module lrc_match
	import lrc_pkg::*;
#(
	parameter int DEPTH = DEPTH_DEF,
	parameter int AGE_W = $clog2(DEPTH)
) (
	input  logic [DEPTH-1:0] valid,
	input  logic [KEY_W-1:0] keys [DEPTH],
	input  logic [AGE_W-1:0] ages [DEPTH],
	input  logic [KEY_W-1:0] key,
	input  logic [CNT_W-1:0] count,
	output logic [DEPTH-1:0] hit_oh,
	output logic [DEPTH-1:0] old_oh
);

	localparam int CMP_W = (AGE_W > CNT_W) ? AGE_W : CNT_W;

	logic [CMP_W-1:0] last_rank;

	// ranks among valid entries run 0..count-1, so the oldest holds count-1
	assign last_rank = CMP_W'(count - CNT_W'(1));

	always_comb begin
		for (int i = 0; i < DEPTH; i++) begin
			hit_oh[i] = valid[i] && (keys[i] == key);
			old_oh[i] = valid[i] && (CMP_W'(ages[i]) == last_rank);
		end
	end

endmodule

`default_nettype wire

FILE: rtl/lru_result_cache.sv
`default_nettype none

// Fully associative lookup cache with least-recently-used replacement.
// A lookup is taken when start is high and busy is low; its result is
// registered and shown on the result ports for exactly one cycle, marked by
// done, and must be taken then: the receiver cannot stall. A new lookup may
// be started every cycle, the whole key compare and recency update being
// combinational logic behind the input register. The one exception is a
// fill after capacity has been lowered below occupancy: the single eviction
// path retires one entry per cycle, so busy stays high while entries beyond
// the first are evicted. occupancy, stored_total, hit_total and miss_total
// show the running state and are meaningful while done is high.
// cfg_ready is always high; capacity is to be written only while idle.
module lru_result_cache
	import lrc_pkg::*;
#(
	parameter int DEPTH = DEPTH_DEF
) (
	input  logic             clk,
	input  logic             arst_n,

	input  logic             cfg_valid,
	output logic             cfg_ready,
	input  logic [CNT_W-1:0] cfg_data,

	input  logic             start,
	output logic             busy,
	input  logic [KEY_W-1:0] lookup_key,
	input  logic             fill_ok,
	input  logic [VAL_W-1:0] fill_value,

	output logic             done,
	output logic             hit,
	output logic [VAL_W-1:0] data_out,
	output logic             evicted,
	output logic [KEY_W-1:0] evicted_key,
	output logic [CNT_W-1:0] occupancy,
	output logic [TOT_W-1:0] stored_total,
	output logic [CTR_W-1:0] hit_total,
	output logic [CTR_W-1:0] miss_total
);

	localparam int AGE_W = $clog2(DEPTH);
	localparam logic [CNT_W-1:0] CAP_TOP = (DEPTH < 16) ? CNT_W'(DEPTH) : '1;

	// state
	logic [CNT_W-1:0] capacity_q;
	logic [DEPTH-1:0] valid_q;
	logic [AGE_W-1:0] age_q [DEPTH];
	logic [KEY_W-1:0] key_q [DEPTH];
	logic [VAL_W-1:0] val_q [DEPTH];
	logic [CNT_W-1:0] count_q;
	logic [SUM_W-1:0] sum_q;
	logic [CTR_W-1:0] hit_cnt_q;
	logic [CTR_W-1:0] miss_cnt_q;
	logic             ev_pend_q;
	logic [KEY_W-1:0] ev_first_q;

	// input register
	logic             valid_s1;
	logic [KEY_W-1:0] key_s1;
	logic             fill_s1;
	logic [VAL_W-1:0] fval_s1;

	// result register
	logic             done_q;
	logic             hit_q;
	logic [VAL_W-1:0] data_q;
	logic             evicted_q;
	logic [KEY_W-1:0] evkey_q;

	logic [CNT_W-1:0] cap_eff;
	logic [DEPTH-1:0] hit_oh;
	logic [DEPTH-1:0] old_oh;
	logic [DEPTH-1:0] valid_after;
	logic [DEPTH-1:0] free_oh;
	logic [DEPTH-1:0] empty_vec;
	logic             hit_any;
	logic             miss_fill;
	logic             drain;
	logic             evict_now;
	logic             complete;
	logic             accept;
	logic [VAL_W-1:0] hit_data;
	logic [AGE_W-1:0] hit_age;
	logic [KEY_W-1:0] old_key;
	logic [VAL_W-1:0] old_val;
	logic [SUM_W-1:0] sum_evict;

	lrc_match #(
		.DEPTH (DEPTH),
		.AGE_W (AGE_W)
	) u_match (
		.valid  (valid_q),
		.keys   (key_q),
		.ages   (age_q),
		.key    (key_s1),
		.count  (count_q),
		.hit_oh (hit_oh),
		.old_oh (old_oh)
	);

	always_comb begin
		cap_eff = capacity_q;
		if (capacity_q == '0) begin
			cap_eff = CNT_W'(1);
		end else if (int'(capacity_q) > DEPTH) begin
			cap_eff = CAP_TOP;
		end
	end

	always_comb begin
		hit_data = '0;
		hit_age  = '0;
		old_key  = '0;
		old_val  = '0;
		for (int i = 0; i < DEPTH; i++) begin
			hit_data = hit_data | (val_q[i] & {VAL_W{hit_oh[i]}});
			hit_age  = hit_age | (age_q[i] & {AGE_W{hit_oh[i]}});
			old_key  = old_key | (key_q[i] & {KEY_W{old_oh[i]}});
			old_val  = old_val | (val_q[i] & {VAL_W{old_oh[i]}});
		end
	end

	assign hit_any   = |hit_oh;
	assign miss_fill = valid_s1 && !hit_any && fill_s1;
	// occupancy above capacity: retire the oldest and hold the beat
	assign drain     = miss_fill && (count_q > cap_eff);
	assign evict_now = miss_fill && !drain && (count_q >= cap_eff);
	assign complete  = valid_s1 && !drain;
	assign busy      = drain;
	assign accept    = start && !busy;
	assign cfg_ready = 1'b1;

	assign valid_after = valid_q & ~(old_oh & {DEPTH{evict_now}});
	// lowest free slot
	assign empty_vec   = ~valid_after;
	assign free_oh     = empty_vec & (~empty_vec + DEPTH'(1));
	assign sum_evict   = sum_q - (evict_now ? SUM_W'(old_val) : '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			capacity_q <= CAP_RESET;
			valid_q    <= '0;
			for (int i = 0; i < DEPTH; i++) begin
				age_q[i] <= '0;
			end
			count_q    <= '0;
			sum_q      <= '0;
			hit_cnt_q  <= '0;
			miss_cnt_q <= '0;
			ev_pend_q  <= 1'b0;
			valid_s1   <= 1'b0;
			done_q     <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				capacity_q <= cfg_data;
			end

			if (accept) begin
				valid_s1 <= 1'b1;
			end else if (complete) begin
				valid_s1 <= 1'b0;
			end

			done_q <= complete;

			if (drain) begin
				valid_q   <= valid_q & ~old_oh;
				count_q   <= count_q - CNT_W'(1);
				sum_q     <= sum_q - SUM_W'(old_val);
				ev_pend_q <= 1'b1;
			end else if (complete) begin
				ev_pend_q <= 1'b0;
				if (hit_any) begin
					if (hit_cnt_q != '1) begin
						hit_cnt_q <= hit_cnt_q + CTR_W'(1);
					end
					for (int i = 0; i < DEPTH; i++) begin
						if (hit_oh[i]) begin
							age_q[i] <= '0;
						end else if (valid_q[i] && age_q[i] < hit_age) begin
							age_q[i] <= age_q[i] + AGE_W'(1);
						end
					end
				end else begin
					if (miss_cnt_q != '1) begin
						miss_cnt_q <= miss_cnt_q + CTR_W'(1);
					end
					if (fill_s1) begin
						valid_q <= valid_after | free_oh;
						if (!evict_now) begin
							count_q <= count_q + CNT_W'(1);
						end
						sum_q <= sum_evict + SUM_W'(fval_s1);
						for (int i = 0; i < DEPTH; i++) begin
							if (free_oh[i]) begin
								age_q[i] <= '0;
							end else if (valid_after[i]) begin
								age_q[i] <= age_q[i] + AGE_W'(1);
							end
						end
					end
				end
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (accept) begin
			key_s1  <= lookup_key;
			fill_s1 <= fill_ok;
			fval_s1 <= fill_value;
		end

		if (drain && !ev_pend_q) begin
			ev_first_q <= old_key;
		end

		if (complete && miss_fill) begin
			for (int i = 0; i < DEPTH; i++) begin
				if (free_oh[i]) begin
					key_q[i] <= key_s1;
					val_q[i] <= fval_s1;
				end
			end
		end

		if (complete) begin
			hit_q     <= hit_any;
			data_q    <= hit_any ? hit_data : (fill_s1 ? fval_s1 : '0);
			evicted_q <= ev_pend_q || evict_now;
			evkey_q   <= ev_pend_q ? ev_first_q : (evict_now ? old_key : '0);
		end
	end

	assign done         = done_q;
	assign hit          = hit_q;
	assign data_out     = data_q;
	assign evicted      = evicted_q;
	assign evicted_key  = evkey_q;
	assign occupancy    = count_q;
	assign stored_total = TOT_W'(sum_q);
	assign hit_total    = hit_cnt_q;
	assign miss_total   = miss_cnt_q;

endmodule

`default_nettype wire

FILE: tb/sv/tb_top.sv
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	import lrc_pkg::*;

	localparam int QUIET_LIMIT = 1000;
	localparam int POOL_SIZE   = 12;

	typedef enum logic {ROW_LOOKUP, ROW_CAPACITY} row_kind_t;

	typedef struct packed {
		logic             hit;
		logic [VAL_W-1:0] data;
		logic             evicted;
		logic [KEY_W-1:0] ev_key;
		logic [CNT_W-1:0] occ;
		logic [TOT_W-1:0] total;
		logic [CTR_W-1:0] hits;
		logic [CTR_W-1:0] misses;
	} lookup_result_t;

	typedef struct packed {
		row_kind_t        kind;
		logic [CNT_W-1:0] cap;
		logic [KEY_W-1:0] key;
		logic             fill;
		logic [VAL_W-1:0] value;
		logic             typed;
		lookup_result_t   want;
	} script_row_t;

	localparam lookup_result_t NO_RESULT = '0;
	localparam logic [KEY_W-1:0] KEY_ONES = '1;
	localparam logic [VAL_W-1:0] VAL_ONES = '1;

	logic             clk = 1'b0;
	logic             arst_n = 1'b0;
	logic             cfg_valid = 1'b0;
	logic             cfg_ready;
	logic [CNT_W-1:0] cfg_data = '0;
	logic             start = 1'b0;
	logic             busy;
	logic [KEY_W-1:0] lookup_key = '0;
	logic             fill_ok = 1'b0;
	logic [VAL_W-1:0] fill_value = '0;
	logic             done;
	logic             hit;
	logic [VAL_W-1:0] data_out;
	logic             evicted;
	logic [KEY_W-1:0] evicted_key;
	logic [CNT_W-1:0] occupancy;
	logic [TOT_W-1:0] stored_total;
	logic [CTR_W-1:0] hit_total;
	logic [CTR_W-1:0] miss_total;

	lru_result_cache dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_data    (cfg_data),
		.start       (start),
		.busy        (busy),
		.lookup_key  (lookup_key),
		.fill_ok     (fill_ok),
		.fill_value  (fill_value),
		.done        (done),
		.hit         (hit),
		.data_out    (data_out),
		.evicted     (evicted),
		.evicted_key (evicted_key),
		.occupancy   (occupancy),
		.stored_total(stored_total),
		.hit_total   (hit_total),
		.miss_total  (miss_total)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// shadow copy of the cache contents and counters
	bit [KEY_W-1:0]   shadow_key[DEPTH_DEF];
	bit [VAL_W-1:0]   shadow_val[DEPTH_DEF];
	bit               shadow_vld[DEPTH_DEF];
	int unsigned      shadow_age[DEPTH_DEF];
	int unsigned      shadow_count = 0;
	bit [TOT_W-1:0]   shadow_sum = '0;
	bit [CTR_W-1:0]   shadow_hits = '0;
	bit [CTR_W-1:0]   shadow_misses = '0;
	bit [CNT_W-1:0]   shadow_cap = CAP_RESET;

	lookup_result_t   pending_results[$];
	script_row_t      script_rows[$];
	int               mismatch_count = 0;
	int               quiet_cycles = 0;

	function automatic void add_row(script_row_t r);
		script_rows = {script_rows, r};
	endfunction

	function automatic void enqueue_result(lookup_result_t r);
		pending_results = {pending_results, r};
	endfunction

	function automatic lookup_result_t cache_lookup(logic [KEY_W-1:0] key, logic fill,
			logic [VAL_W-1:0] value);
		lookup_result_t r;
		int slot;
		int victim;
		int unsigned lim;
		int unsigned old_age;
		r = '0;
		slot = -1;
		for (int i = 0; i < DEPTH_DEF; i++)
			if (shadow_vld[i] && shadow_key[i] == key && slot < 0)
				slot = i;
		if (slot >= 0) begin
			r.hit = 1'b1;
			r.data = shadow_val[slot];
			old_age = shadow_age[slot];
			for (int i = 0; i < DEPTH_DEF; i++)
				if (shadow_vld[i] && i != slot && shadow_age[i] < old_age)
					shadow_age[i]++;
			shadow_age[slot] = 0;
			if (shadow_hits != '1)
				shadow_hits++;
		end else begin
			if (shadow_misses != '1)
				shadow_misses++;
			if (fill) begin
				lim = (shadow_cap == 0) ? 1 : (shadow_cap > DEPTH_DEF ? DEPTH_DEF : shadow_cap);
				r.data = value;
				// capacity may have dropped below occupancy: retire oldest until it fits
				while (shadow_count >= lim && shadow_count > 0) begin
					victim = -1;
					for (int i = 0; i < DEPTH_DEF; i++)
						if (shadow_vld[i] && (victim < 0 || shadow_age[i] > shadow_age[victim]))
							victim = i;
					shadow_vld[victim] = 1'b0;
					shadow_age[victim] = 0;
					shadow_sum -= shadow_val[victim];
					shadow_count--;
					if (!r.evicted)
						r.ev_key = shadow_key[victim];
					r.evicted = 1'b1;
				end
				slot = -1;
				for (int i = 0; i < DEPTH_DEF; i++)
					if (!shadow_vld[i] && slot < 0)
						slot = i;
				for (int i = 0; i < DEPTH_DEF; i++)
					if (shadow_vld[i])
						shadow_age[i]++;
				shadow_vld[slot] = 1'b1;
				shadow_key[slot] = key;
				shadow_val[slot] = value;
				shadow_age[slot] = 0;
				shadow_count++;
				shadow_sum += value;
			end
		end
		r.occ = shadow_count[CNT_W-1:0];
		r.total = shadow_sum;
		r.hits = shadow_hits;
		r.misses = shadow_misses;
		return r;
	endfunction

	task automatic report_mismatch(string msg);
		$display("%0t: %s", $time, msg);
		mismatch_count++;
	endtask

	task automatic check_field(string name, logic [63:0] got, logic [63:0] want);
		if (got !== want)
			report_mismatch($sformatf("%s: got %0h, expected %0h", name, got, want));
	endtask

	always @(posedge clk) begin
		lookup_result_t want;
		if (arst_n && done) begin
			if (pending_results.size() == 0) begin
				report_mismatch("result beat with nothing outstanding");
			end else begin
				want = pending_results.pop_front();
				check_field("hit", hit, want.hit);
				check_field("data_out", data_out, want.data);
				check_field("evicted", evicted, want.evicted);
				check_field("evicted_key", evicted_key, want.ev_key);
				check_field("occupancy", occupancy, want.occ);
				check_field("stored_total", stored_total, want.total);
				check_field("hit_total", hit_total, want.hits);
				check_field("miss_total", miss_total, want.misses);
			end
		end
	end

	// watchdog on cycles with no beat on any channel
	always @(posedge clk) begin
		if ((start && !busy) || done || (cfg_valid && cfg_ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("Mismatches found");
			$finish;
		end
	end

	task automatic send_lookup(logic [KEY_W-1:0] key, logic fill, logic [VAL_W-1:0] value,
			logic typed, lookup_result_t want);
		lookup_result_t predicted;
		start <= 1'b1;
		lookup_key <= key;
		fill_ok <= fill;
		fill_value <= value;
		do
			@(posedge clk);
		while (busy);
		predicted = cache_lookup(key, fill, value);
		enqueue_result(typed ? want : predicted);
	endtask

	task automatic drain;
		while (pending_results.size() != 0)
			@(posedge clk);
	endtask

	// only called with start low; the wait after the drain covers any trailing eviction work
	task automatic write_capacity(logic [CNT_W-1:0] cap);
		drain();
		repeat (4) @(posedge clk);
		cfg_valid <= 1'b1;
		cfg_data <= cap;
		do
			@(posedge clk);
		while (!cfg_ready);
		cfg_valid <= 1'b0;
		shadow_cap = cap;
	endtask

	function automatic logic [VAL_W-1:0] pick_value();
		case ($urandom_range(0, 15))
			0: return '0;
			1: return VAL_ONES;
			default: return $urandom;
		endcase
	endfunction

	initial begin
		script_row_t       row;
		logic [KEY_W-1:0]  key_pool[POOL_SIZE];
		logic [KEY_W-1:0]  key;
		logic [CNT_W-1:0]  phase_caps[13];
		int                span;
		int                burst;
		int                sent;

		phase_caps = '{4'd8, 4'd1, 4'd3, 4'd0, 4'd15, 4'd5, 4'd2, 4'd9, 4'd6, 4'd4, 4'd12,
			4'd7, 4'd8};

		// after reset: typed-in expectations
		add_row('{ROW_LOOKUP, 4'd0, 64'd0, 1'b0, VAL_ONES, 1'b1,
			'{1'b0, 32'd0, 1'b0, 64'd0, 4'd0, 36'd0, 32'd0, 32'd1}});
		add_row('{ROW_LOOKUP, 4'd0, KEY_ONES, 1'b1, VAL_ONES, 1'b1,
			'{1'b0, VAL_ONES, 1'b0, 64'd0, 4'd1, 36'h0_FFFF_FFFF, 32'd0, 32'd2}});
		add_row('{ROW_LOOKUP, 4'd0, KEY_ONES, 1'b0, 32'd0, 1'b1,
			'{1'b1, VAL_ONES, 1'b0, 64'd0, 4'd1, 36'h0_FFFF_FFFF, 32'd1, 32'd2}});
		add_row('{ROW_LOOKUP, 4'd0, 64'd0, 1'b1, 32'd0, 1'b1,
			'{1'b0, 32'd0, 1'b0, 64'd0, 4'd2, 36'h0_FFFF_FFFF, 32'd1, 32'd3}});
		add_row('{ROW_LOOKUP, 4'd0, 64'd0, 1'b1, 32'd5, 1'b1,
			'{1'b1, 32'd0, 1'b0, 64'd0, 4'd2, 36'h0_FFFF_FFFF, 32'd2, 32'd3}});
		// fill up to eight entries, then one more evicts the least recent
		add_row('{ROW_LOOKUP, 4'd0, 64'h1, 1'b1, 32'h1, 1'b0, NO_RESULT});
		add_row('{ROW_LOOKUP, 4'd0, 64'h8000_0000_0000_0000, 1'b1, 32'h8000_0000,
			1'b0, NO_RESULT});
		add_row('{ROW_LOOKUP, 4'd0, 64'h5555_5555_5555_5555, 1'b1, VAL_ONES, 1'b0,
			NO_RESULT});
		add_row('{ROW_LOOKUP, 4'd0, 64'hAAAA_AAAA_AAAA_AAAA, 1'b1, 32'hAAAA_AAAA,
			1'b0, NO_RESULT});
		add_row('{ROW_LOOKUP, 4'd0, 64'h1_0000_0000, 1'b1, 32'h5555_5555, 1'b0,
			NO_RESULT});
		add_row('{ROW_LOOKUP, 4'd0, 64'h2, 1'b1, VAL_ONES, 1'b0, NO_RESULT});
		add_row('{ROW_LOOKUP, 4'd0, 64'h3, 1'b1, 32'h7, 1'b0, NO_RESULT});
		add_row('{ROW_LOOKUP, 4'd0, KEY_ONES, 1'b0, 32'h9, 1'b0, NO_RESULT});
		// capacity lowered below occupancy: the next fill evicts a run of entries
		add_row('{ROW_CAPACITY, 4'd2, 64'd0, 1'b0, 32'd0, 1'b0, NO_RESULT});
		add_row('{ROW_LOOKUP, 4'd0, 64'h5555_5555_5555_5555, 1'b1, 32'd3, 1'b0,
			NO_RESULT});
		add_row('{ROW_LOOKUP, 4'd0, 64'h100, 1'b1, 32'h1234, 1'b0, NO_RESULT});
		// zero capacity acts as one entry
		add_row('{ROW_CAPACITY, 4'd0, 64'd0, 1'b0, 32'd0, 1'b0, NO_RESULT});
		add_row('{ROW_LOOKUP, 4'd0, 64'h200, 1'b1, 32'h10, 1'b0, NO_RESULT});
		add_row('{ROW_LOOKUP, 4'd0, 64'h200, 1'b0, 32'h0, 1'b0, NO_RESULT});
		// capacity beyond the store size acts as full depth
		add_row('{ROW_CAPACITY, 4'd15, 64'd0, 1'b0, 32'd0, 1'b0, NO_RESULT});
		add_row('{ROW_LOOKUP, 4'd0, 64'h300, 1'b1, 32'h20, 1'b0, NO_RESULT});
		add_row('{ROW_LOOKUP, 4'd0, 64'h200, 1'b0, 32'h0, 1'b0, NO_RESULT});

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (script_rows[i]) begin
			row = script_rows[i];
			if (row.kind == ROW_CAPACITY) begin
				start <= 1'b0;
				write_capacity(row.cap);
			end else begin
				send_lookup(row.key, row.fill, row.value, row.typed, row.want);
			end
		end
		start <= 1'b0;

		foreach (phase_caps[p]) begin
			write_capacity(phase_caps[p]);
			foreach (key_pool[k])
				case ($urandom_range(0, 9))
					0: key_pool[k] = '0;
					1: key_pool[k] = KEY_ONES;
					default: key_pool[k] = {$urandom, $urandom};
				endcase
			// a working set a little larger than the capacity gives both hits and evictions
			span = (phase_caps[p] == 0) ? 3 : (phase_caps[p] > 8 ? 11 : phase_caps[p] + 3);
			sent = 0;
			while (sent < 77) begin
				burst = $urandom_range(1, 20);
				repeat (burst) begin
					if ($urandom_range(0, 6) == 0)
						key = {$urandom, $urandom};
					else
						key = key_pool[$urandom_range(0, span - 1)];
					send_lookup(key, $urandom_range(0, 3) != 0, pick_value(), 1'b0, NO_RESULT);
					sent++;
				end
				case ($urandom_range(0, 9))
					0, 1: ;
					2: begin
						start <= 1'b0;
						drain();
					end
					default: begin
						start <= 1'b0;
						repeat ($urandom_range(1, 8)) @(posedge clk);
					end
				endcase
			end
			start <= 1'b0;
		end

		drain();
		repeat (10) @(posedge clk);
		if (mismatch_count == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule
